FILE: src/assert_macros.svh
// Assertion helpers for the odometry block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, clocked on the rising edge, off while in reset.
`define TWO_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("odometry assertion failed");

// Same, with an implication written out.
`define TWO_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("odometry implication failed");

`endif

FILE: src/two_pkg.sv
package two_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int POS_BITS     = 32;
  localparam int CORDIC_STEPS = 20;
  localparam int CW           = 34;  // cordic datapath width
  localparam int TRIG_W       = 24;  // Q20 sine/cosine
  localparam int AW           = 66;  // rotation accumulator width

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  localparam logic signed [AW-1:0] POS_HI = (66'sd1 <<< (POS_BITS - 1)) - 66'sd1;
  localparam logic signed [AW-1:0] POS_LO = -POS_HI - 66'sd1;

  typedef enum logic [1:0] {
    CFG_SIDE_SCALE = 2'd0,
    CFG_BACK_SCALE = 2'd1,
    CFG_ARC_GAIN   = 2'd2,
    CFG_NONE       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                 valid;
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  function automatic logic signed [CW-1:0] atan_at(logic [4:0] step);
    logic signed [CW-1:0] v;
    case (step)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Heading cut to ANGLE_BITS and placed at the top of a 32-bit phase.
  function automatic logic [31:0] heading_phase(logic [15:0] h);
    logic [63:0] a;
    logic [63:0] b;
    if (ANGLE_BITS >= 16) begin
      a = {48'b0, h} << (ANGLE_BITS - 16);
    end else begin
      a = {48'b0, h} >> (16 - ANGLE_BITS);
    end
    b = a << (32 - ANGLE_BITS);
    return b[31:0];
  endfunction

  function automatic logic signed [POS_BITS-1:0] sat_pos(logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    if (v > POS_HI) begin
      r = POS_HI;
    end else if (v < POS_LO) begin
      r = POS_LO;
    end else begin
      r = v;
    end
    return r[POS_BITS-1:0];
  endfunction

endpackage

FILE: src/two_cordic_cell.sv
module two_cordic_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [4:0]        step_i,
  input  two_pkg::cordic_t  cin_i,
  output two_pkg::cordic_t  cout_o
);
  import two_pkg::*;

  cordic_t              cell_d, cell_q;
  logic signed [CW-1:0] tx, ty, ang;

  always_comb begin
    tx  = cin_i.y >>> step_i;
    ty  = cin_i.x >>> step_i;
    ang = atan_at(step_i);
    cell_d = cin_i;
    if (!cin_i.z[CW-1]) begin
      cell_d.x = cin_i.x - tx;
      cell_d.y = cin_i.y + ty;
      cell_d.z = cin_i.z - ang;
    end else begin
      cell_d.x = cin_i.x + tx;
      cell_d.y = cin_i.y - ty;
      cell_d.z = cin_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cout_o = cell_q;

endmodule

FILE: src/two_cordic_chain.sv
module two_cordic_chain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  two_pkg::cordic_t  cin_i,
  output two_pkg::cordic_t  cout_o
);
  import two_pkg::*;

  cordic_t link [CORDIC_STEPS+1];

  assign link[0] = cin_i;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    two_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (5'(i)),
      .cin_i  (link[i]),
      .cout_o (link[i+1])
    );
  end

  assign cout_o = link[CORDIC_STEPS];

endmodule

FILE: src/tracking_wheel_odometry_top.sv
// Tracking-wheel odometry: each input item is one sample of the left, right and back
// encoder counts plus the gyro heading; each item yields exactly one output item with
// the global x/y position (1/1024 cm, saturating) and a flag that is set when the
// position was updated. An item taken while calibrating clears the position and the
// first item afterwards (or after reset) only records the counts. A regular item
// passes the row of CORDIC cells that forms sine and cosine of the heading, then
// one shared 22x24 multiplier that rotates the local offset, then the saturating
// update. One item is in work at a time; the output register lets the next item in
// while a result waits to be taken. Registers are to be written through the cfg port
// only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module tracking_wheel_odometry_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  // config write channel
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  // sample stream in
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,  // left_count, right_count, back_count, heading
  input  logic          s_axis_tuser,  // calibrating
  // position stream out
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,  // pos_x, pos_y
  output logic          m_axis_tuser   // position_valid
);
  import two_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCALE = 8'b0000_0010,
    S_ROUND = 8'b0000_0100,
    S_ROT   = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_SUM   = 8'b0010_0000,
    S_UPD   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [15:0] side_q, back_q, gain_q;

  // unpacked input item
  logic [31:0] in_l, in_r, in_b;
  logic [15:0] in_h;
  logic        in_cal, accept;

  assign in_l   = s_axis_tdata[31:0];
  assign in_r   = s_axis_tdata[63:32];
  assign in_b   = s_axis_tdata[95:64];
  assign in_h   = s_axis_tdata[111:96];
  assign in_cal = s_axis_tuser;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // odometry state
  logic [31:0]                last_l_q, last_r_q, last_b_q;
  logic [15:0]                last_h_q;
  logic signed [POS_BITS-1:0] acc_x_q, acc_y_q;
  logic                       primed_q;

  // deltas and scaled offsets
  logic [31:0]        dl, dr, db;
  logic [15:0]        dh;
  logic signed [32:0] dsum_q;
  logic signed [31:0] db_q;
  logic signed [15:0] dh_q;
  logic signed [49:0] pf_q;
  logic signed [48:0] pb_q;
  logic signed [32:0] pa_q;
  logic signed [49:0] f_full, s_sum, s_full;
  logic signed [40:0] f_q, s_q;

  assign dl = in_l - last_l_q;
  assign dr = in_r - last_r_q;
  assign db = in_b - last_b_q;
  assign dh = in_h - last_h_q;

  assign f_full = (pf_q + 50'sd256) >>> 9;
  assign s_sum  = {pb_q[48], pb_q} + {{17{pa_q[32]}}, pa_q};
  assign s_full = (s_sum + 50'sd128) >>> 8;

  // sine / cosine through the cell row
  logic [31:0] phase, phase_f;
  logic        fold;
  cordic_t     chain_in, chain_out;

  assign phase   = heading_phase(in_h);
  assign fold    = phase[31] ^ phase[30];  // top bit of phase + quarter turn
  assign phase_f = fold ? (phase + 32'h8000_0000) : phase;

  always_comb begin
    chain_in.valid = accept && !in_cal && primed_q;
    chain_in.flip  = fold;
    chain_in.x     = CORDIC_K;
    chain_in.y     = '0;
    chain_in.z     = {{(CW-32){phase_f[31]}}, phase_f};
  end

  two_cordic_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cin_i  (chain_in),
    .cout_o (chain_out)
  );

  logic signed [CW-1:0]     cos_r, sin_r;
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic                     trig_ok_q;

  assign cos_r = (chain_out.x + 34'sd512) >>> 10;
  assign sin_r = (chain_out.y + 34'sd512) >>> 10;

  // shared rotation multiplier, 8 partial products
  logic [2:0]               k_q, pk_q;
  logic                     pv_q;
  logic signed [21:0]       a_op;
  logic signed [TRIG_W-1:0] b_op;
  logic signed [45:0]       prod_q;
  logic signed [AW-1:0]     term, rx_q, ry_q;
  logic                     k_hi, k_useS, k_toY, k_cos;

  assign k_hi   = k_q[0];
  assign k_useS = k_q[1];
  assign k_toY  = k_q[2];
  assign k_cos  = k_useS ^ k_toY;

  always_comb begin
    case ({k_useS, k_hi})
      2'b00:   a_op = {1'b0, f_q[20:0]};
      2'b01:   a_op = {{2{f_q[40]}}, f_q[40:21]};
      2'b10:   a_op = {1'b0, s_q[20:0]};
      2'b11:   a_op = {{2{s_q[40]}}, s_q[40:21]};
      default: a_op = '0;
    endcase
    b_op = k_cos ? cos_q : sin_q;
  end

  assign term = pk_q[0] ? ({{20{prod_q[45]}}, prod_q} <<< 21)
                        : {{20{prod_q[45]}}, prod_q};

  // final update
  logic signed [AW-1:0] dx, dy, nx, ny;
  logic signed [POS_BITS-1:0] sat_x, sat_y;

  assign dx = (rx_q + 66'sd524288) >>> 20;
  assign dy = (ry_q + 66'sd524288) >>> 20;
  assign nx = dx + {{(AW-POS_BITS){acc_x_q[POS_BITS-1]}}, acc_x_q};
  assign ny = dy + {{(AW-POS_BITS){acc_y_q[POS_BITS-1]}}, acc_y_q};
  assign sat_x = sat_pos(nx);
  assign sat_y = sat_pos(ny);

  // result and output register
  logic [31:0] res_x_q, res_y_q, out_x_q, out_y_q;
  logic        res_v_q, out_v_q, out_valid_q, out_load;

  assign out_load = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_cal || !primed_q) ? S_FIN : S_SCALE;
        end
      end
      S_SCALE: state_d = S_ROUND;
      S_ROUND: state_d = S_ROT;
      S_ROT: begin
        if (trig_ok_q) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (k_q == 3'd7) begin
          state_d = S_SUM;
        end
      end
      S_SUM: state_d = S_UPD;
      S_UPD: state_d = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      side_q      <= 16'd14564;
      back_q      <= 16'd18860;
      gain_q      <= 16'd421;
      last_l_q    <= '0;
      last_r_q    <= '0;
      last_b_q    <= '0;
      last_h_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      primed_q    <= 1'b0;
      trig_ok_q   <= 1'b0;
      k_q         <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SIDE_SCALE: side_q <= cfg_data_i;
          CFG_BACK_SCALE: back_q <= cfg_data_i;
          CFG_ARC_GAIN:   gain_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (accept) begin
        if (in_cal) begin
          acc_x_q  <= '0;
          acc_y_q  <= '0;
          primed_q <= 1'b0;
        end else begin
          primed_q <= 1'b1;
          last_l_q <= in_l;
          last_r_q <= in_r;
          last_b_q <= in_b;
          last_h_q <= in_h;
        end
      end

      if (chain_out.valid) begin
        trig_ok_q <= 1'b1;
      end else if (state_q == S_ROT && trig_ok_q) begin
        trig_ok_q <= 1'b0;
      end

      if (state_q == S_MUL) begin
        k_q <= k_q + 3'd1;
      end else begin
        k_q <= '0;
      end
      pv_q <= (state_q == S_MUL);

      if (state_q == S_UPD) begin
        acc_x_q <= sat_x;
        acc_y_q <= sat_y;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dsum_q <= {dl[31], dl} + {dr[31], dr};
      db_q   <= db;
      dh_q   <= dh;
      // early results for calibrating and first samples
      res_x_q <= in_cal ? '0 : 32'(acc_x_q);
      res_y_q <= in_cal ? '0 : 32'(acc_y_q);
      res_v_q <= 1'b0;
    end
    if (state_q == S_SCALE) begin
      pf_q <= dsum_q * $signed({1'b0, side_q});
      pb_q <= db_q * $signed({1'b0, back_q});
      pa_q <= dh_q * $signed({1'b0, gain_q});
    end
    if (state_q == S_ROUND) begin
      f_q <= f_full[40:0];
      s_q <= s_full[40:0];
    end
    if (chain_out.valid) begin
      cos_q <= chain_out.flip ? -cos_r[TRIG_W-1:0] : cos_r[TRIG_W-1:0];
      sin_q <= chain_out.flip ? -sin_r[TRIG_W-1:0] : sin_r[TRIG_W-1:0];
    end
    if (state_q == S_MUL) begin
      prod_q <= a_op * b_op;
      pk_q   <= k_q;
    end
    if (state_q == S_ROT) begin
      rx_q <= '0;
      ry_q <= '0;
    end else if (pv_q) begin
      if (!pk_q[2]) begin
        rx_q <= rx_q + term;
      end else if (pk_q[1]) begin
        ry_q <= ry_q - term;
      end else begin
        ry_q <= ry_q + term;
      end
    end
    if (state_q == S_UPD) begin
      res_x_q <= 32'(sat_x);
      res_y_q <= 32'(sat_y);
      res_v_q <= 1'b1;
    end
    if (out_load) begin
      out_x_q <= res_x_q;
      out_y_q <= res_y_q;
      out_v_q <= res_v_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = out_v_q;

  // checks
  `TWO_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
  `TWO_ASSERT_IMPL(a_trig_in_rot, clk_i, rst_ni, chain_out.valid, state_q == S_ROT)
  `TWO_ASSERT(a_mul_len, clk_i, rst_ni, (state_q == S_MUL && k_q == 3'd7) |=> state_q == S_SUM)
  `TWO_ASSERT(a_delta_path, clk_i, rst_ni, (accept && !in_cal && primed_q) |=> state_q == S_SCALE)

endmodule

FILE: sim/tb_tracking_wheel_odometry_top.sv
`timescale 1ns / 1ps

module tb_tracking_wheel_odometry_top;
  import two_pkg::*;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] back;
    logic [15:0] heading;
    logic        cal;
  } sample_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic        moved;
  } pos_t;

  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 950;
  localparam int HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;

  tracking_wheel_odometry_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: configuration and the odometry track.
  logic [15:0] side_gain, back_gain, arc_gain;
  logic [31:0] prev_l, prev_r, prev_b;
  logic [15:0] prev_h;
  longint trk_x, trk_y;
  bit primed;

  sample_t sample_q[$];   // items waiting for the driver
  pos_t pos_q[$];         // predicted positions, oldest first
  int errors = 0;
  int n_moved = 0;
  int n_out = 0;
  bit idle_on = 1'b1;     // random idling enable
  bit hold_rx;            // receiver held off entirely
  bit hold_req = 1'b0;    // asks for one long receiver hold
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int idle_pct = 32;

  // half-up rounding shift on a signed 64-bit value
  function automatic longint rshr(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clamp_pos(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (POS_BITS - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic void trig_q20(logic [15:0] h, output longint s, output longint c);
    longint x, y, z, tx, ty;
    logic [31:0] ph;
    bit flip;
    longint angles[20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                           21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                           333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304};
    ph = {h, 16'h0};  // ANGLE_BITS = 16
    flip = 1'b0;
    if (((ph + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      flip = 1'b1;
      ph = ph + 32'h8000_0000;
    end
    x = 652032874;
    y = 0;
    z = longint'(signed'(ph));
    for (int i = 0; i < 20; i++) begin
      tx = y >>> i;
      ty = x >>> i;
      if (z >= 0) begin
        x -= tx; y += ty; z -= angles[i];
      end else begin
        x += tx; y -= ty; z += angles[i];
      end
    end
    c = rshr(x, 10);
    s = rshr(y, 10);
    if (flip) begin
      c = -c; s = -s;
    end
  endfunction

  function automatic pos_t track_sample(sample_t it);
    pos_t r;
    longint dl, dr, db, dh, f, sd, s, c;
    r.moved = 1'b0;
    if (it.cal) begin
      trk_x = 0; trk_y = 0; primed = 1'b0;
    end else if (!primed) begin
      primed = 1'b1;
    end else begin
      dl = longint'(signed'(it.left - prev_l));
      dr = longint'(signed'(it.right - prev_r));
      db = longint'(signed'(it.back - prev_b));
      dh = longint'(signed'(16'(it.heading - prev_h)));
      f = rshr(dl * side_gain + dr * side_gain, 9);
      sd = rshr(db * back_gain + dh * arc_gain, 8);
      trig_q20(it.heading, s, c);
      trk_x = clamp_pos(trk_x + rshr(f * s + sd * c, 20));
      trk_y = clamp_pos(trk_y + rshr(f * c - sd * s, 20));
      r.moved = 1'b1;
    end
    if (!it.cal) begin
      prev_l = it.left; prev_r = it.right; prev_b = it.back; prev_h = it.heading;
    end
    r.px = trk_x[31:0];
    r.py = trk_y[31:0];
    return r;
  endfunction

  // Driver: offers queued items, predicts on acceptance.
  always @(posedge clk_i) begin
    sample_t nx;
    if (s_axis_tvalid && s_axis_tready) begin
      nx = {s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64],
            s_axis_tdata[111:96], s_axis_tuser};
      pos_q.push_back(track_sample(nx));
      void'(sample_q.pop_front());
    end
    if (rst_ni && sample_q.size() > ((s_axis_tvalid && s_axis_tready) ? 0 : 0) &&
        !(idle_on && $urandom_range(99) < idle_pct)) begin
      nx = sample_q[0];
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {nx.heading, nx.back, nx.right, nx.left};
      s_axis_tuser <= nx.cal;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver hold: one long stretch, counted here once requested.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  assign hold_rx = (hold_cnt != 0);

  // Monitor: random back-pressure and result checking.
  always @(posedge clk_i) begin
    pos_t got, exp_pos;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
      n_out++;
      if (got.moved) n_moved++;
      if (pos_q.size() == 0) begin
        errors++;
        $display("%t unexpected result x=%0d y=%0d", $time, $signed(got.px),
                 $signed(got.py));
      end else begin
        exp_pos = pos_q.pop_front();
        if (got.px !== exp_pos.px) begin
          errors++;
          $display("%t pos_x exp %0d got %0d", $time, $signed(exp_pos.px), $signed(got.px));
        end
        if (got.py !== exp_pos.py) begin
          errors++;
          $display("%t pos_y exp %0d got %0d", $time, $signed(exp_pos.py), $signed(got.py));
        end
        if (got.moved !== exp_pos.moved) begin
          errors++;
          $display("%t position_valid exp %0b got %0b", $time, exp_pos.moved, got.moved);
        end
      end
    end
    m_axis_tready <= rst_ni && !hold_rx && !(idle_on && $urandom_range(99) < idle_pct);
  end

  // Watchdog on cycles without any handshake.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG);
        $display("tb_tracking_wheel_odometry_top: errors");
        $finish;
      end
    end
  end

  task automatic drain();
    wait (sample_q.size() == 0);
    @(posedge clk_i);
    while (s_axis_tvalid || pos_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Register write; block is idle whenever this is called.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SIDE_SCALE: side_gain = val;
      CFG_BACK_SCALE: back_gain = val;
      CFG_ARC_GAIN:   arc_gain = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic sample_t rnd_sample(sample_t base, int span, bit cal);
    sample_t it;
    it.left = base.left + 32'($signed($urandom_range(2 * span)) - span);
    it.right = base.right + 32'($signed($urandom_range(2 * span)) - span);
    it.back = base.back + 32'($signed($urandom_range(2 * span)) - span);
    it.heading = 16'($urandom);
    it.cal = cal;
    return it;
  endfunction

  initial begin
    sample_t it, last;
    side_gain = 16'd14564; back_gain = 16'd18860; arc_gain = 16'd421;
    prev_l = '0; prev_r = '0; prev_b = '0; prev_h = '0;
    trk_x = 0; trk_y = 0; primed = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: priming, headings at quadrant edges, count wrap, calibration,
    // full-scale deltas driving the position into saturation.
    sample_q.push_back('{32'd0, 32'd0, 32'd0, 16'h0000, 1'b0});
    sample_q.push_back('{32'd1000, 32'd1000, 32'd0, 16'h0000, 1'b0});
    sample_q.push_back('{32'd2000, 32'd2000, 32'd50, 16'h4000, 1'b0});
    sample_q.push_back('{32'd3000, 32'd2500, 32'd60, 16'h8000, 1'b0});
    sample_q.push_back('{32'd3500, 32'd3000, 32'd70, 16'hC000, 1'b0});
    sample_q.push_back('{32'd3600, 32'd3100, 32'd80, 16'hFFFF, 1'b0});
    sample_q.push_back('{32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h8000_0000, 16'h3FFF, 1'b0});
    sample_q.push_back('{32'h8000_0010, 32'h8000_0010, 32'h7FFF_FFFF, 16'h4001, 1'b0});
    sample_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 1'b0});
    sample_q.push_back('{32'h0000_0005, 32'h0000_0005, 32'h0000_0003, 16'h8001, 1'b0});
    sample_q.push_back('{32'h1234_5678, 32'hDEAD_BEEF, 32'h5555_AAAA, 16'hAAAA, 1'b1});
    sample_q.push_back('{32'h1234_5678, 32'hDEAD_BEEF, 32'h5555_AAAA, 16'h5555, 1'b0});
    sample_q.push_back('{32'h1234_5678, 32'hDEAD_BEEF, 32'h5555_AAAA, 16'h5555, 1'b0});
    drain();
    write_reg(CFG_SIDE_SCALE, 16'hFFFF);
    write_reg(CFG_BACK_SCALE, 16'hFFFF);
    write_reg(CFG_ARC_GAIN, 16'hFFFF);
    for (int i = 0; i < 8; i++) begin
      sample_q.push_back('{32'(i) * 32'h7FFF_FFFF, 32'(i) * 32'h7FFF_FFFF,
                          32'(i) * 32'h8000_0001, 16'(i * 16'h2000), 1'b0});
    end
    sample_q.push_back('{32'h0, 32'h0, 32'h0, 16'h0, 1'b0});
    drain();
    write_reg(CFG_SIDE_SCALE, 16'h0000);
    write_reg(CFG_BACK_SCALE, 16'h0000);
    write_reg(CFG_ARC_GAIN, 16'h0000);
    sample_q.push_back('{32'h0, 32'h0, 32'h0, 16'h0, 1'b1});
    sample_q.push_back('{32'h10, 32'h20, 32'h30, 16'h1000, 1'b0});
    sample_q.push_back('{32'h11, 32'h22, 32'h33, 16'h2000, 1'b0});
    drain();

    // Random phases with different register settings.
    last = '0;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_SIDE_SCALE, ph == 0 ? 16'd14564 : 16'($urandom));
      write_reg(CFG_BACK_SCALE, ph == 0 ? 16'd18860 : 16'($urandom));
      write_reg(CFG_ARC_GAIN, ph == 0 ? 16'd421 : 16'($urandom));
      idle_on = (ph != 2);  // one phase without any idling
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        case ($urandom_range(19))
          0: it = rnd_sample(last, 100, 1'b1);
          1: it = '{32'($urandom), 32'($urandom), 32'($urandom), 16'($urandom), 1'b0};
          2: it = rnd_sample(last, 32'h3FFF_FFFF, 1'b0);
          default: it = rnd_sample(last, $urandom_range(1) ? 50 : 5000, 1'b0);
        endcase
        last = it;
        sample_q.push_back(it);
        // receiver held off while the sender keeps offering
        if (ph == 1 && i == 20) begin
          hold_req = 1'b1;
        end
      end
      drain();  // sender pauses until every result is back
    end

    $display("covered %0d results, %0d with a moved position, 8 register settings",
             n_out, n_moved);
    if (errors == 0) begin
      $display("tb_tracking_wheel_odometry_top: clean");
    end else begin
      $display("tb_tracking_wheel_odometry_top: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/two_pkg.sv
src/two_cordic_cell.sv
src/two_cordic_chain.sv
src/tracking_wheel_odometry_top.sv
sim/tb_tracking_wheel_odometry_top.sv
